FILE: hw/rtl/hd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hd_pkg
// Types and constants shared by the histogram distance core: request and
// result structs, metric codes, accumulator widths and step counts.
// ----------------------------------------------------------------------------
package hd_pkg;

  localparam int BIN_W  = 16;   // width of one bin count on the port
  localparam int DIST_W = 36;   // distance, 16 fraction bits
  localparam int SSD_W  = 40;   // sum of squared differences
  localparam int SUM_W  = 24;   // per-histogram bin sum
  localparam int BC_W   = 32;   // sum of floor(sqrt(a*b))
  localparam int PROD_W = 64;   // shared multiplier product
  localparam int P_W    = 48;   // sum_first * sum_second
  localparam int UNIT_W = 49;   // shared compare/subtract unit
  localparam int RAD_W  = 72;   // root radicand shift register
  localparam int CNT_W  = 6;    // step counter

  // Root step counts (digit pairs) for each radicand, and the divide step count
  localparam logic [CNT_W-1:0] STEPS_BIN = 6'd16;  // a*b, 32 bits
  localparam logic [CNT_W-1:0] STEPS_EUC = 6'd36;  // ssd * 2^32, 72 bits
  localparam logic [CNT_W-1:0] STEPS_HS  = 6'd32;  // ratio * 2^64 (frac * 2^32), 64 bits
  localparam logic [CNT_W-1:0] STEPS_HD  = 6'd17;  // radicand, 34 bits
  localparam logic [CNT_W-1:0] STEPS_DIV = 6'd32;  // fraction bits of BC^2/P

  localparam logic METRIC_L2   = 1'b0;
  localparam logic METRIC_HELL = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic [BIN_W-1:0] bin_a;
    logic [BIN_W-1:0] bin_b;
    logic             last_bin;
  } hd_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              status;
  } hd_rsp_t;

  // What the root sequence feeds when it finishes
  typedef enum logic [1:0] {
    RT_BIN = 2'd0,   // per-bin sqrt(a*b)
    RT_EUC = 2'd1,   // euclidean distance
    RT_HS  = 2'd2,   // hellinger ratio BC/sqrt(P)
    RT_HD  = 2'd3    // hellinger distance
  } hd_root_mode_t;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MULAB  = 12'b0000_0000_0010,
    S_MULDD  = 12'b0000_0000_0100,
    S_ACC    = 12'b0000_0000_1000,
    S_ROOT   = 12'b0000_0001_0000,
    S_BCACC  = 12'b0000_0010_0000,
    S_FINAL  = 12'b0000_0100_0000,
    S_MULP   = 12'b0000_1000_0000,
    S_MULBC  = 12'b0001_0000_0000,
    S_DIVCHK = 12'b0010_0000_0000,
    S_DIV    = 12'b0100_0000_0000,
    S_SQS    = 12'b1000_0000_0000
  } hd_state_t;

endpackage

FILE: hw/rtl/histogram_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_distance_core
// Euclidean or Hellinger distance of two histograms fed as paired bins, built
// around one 32x32 multiplier and one 49-bit compare/subtract unit.
// ----------------------------------------------------------------------------
//  channel   ports                      handshake
//  request   start, busy, req           taken when start & !busy
//  result    done, rsp                  one-cycle strobe, no back-pressure
//  config    cfg_write, cfg_wdata       metric_select, written on cfg_write
//
//  A bin pair holds busy through S_MULAB, S_MULDD and S_ACC, 16 root
//  steps on the shared compare/subtract unit and one update.
//  The last pair adds a square root (euclidean) or, for hellinger,
//  two products, 32 divide steps, a 32-step and a 17-step root.
//  Pairs past MAX_BINS are taken without accumulating.
//  Synchronous reset clears the accumulators and metric_select.
//  Results are never stalled; done may pulse while the next request is taken.
// ----------------------------------------------------------------------------
module histogram_distance_core
  import hd_pkg::*;
#(
  parameter int MAX_BINS = 256,
  parameter int BIN_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  hd_req_t req,
  output logic    done,
  output hd_rsp_t rsp,
  input  logic    cfg_write,
  input  logic    cfg_wdata
);

  localparam int CW = $clog2(MAX_BINS + 1);
  localparam logic [CW-1:0] BIN_LIMIT = CW'(MAX_BINS);

  hd_state_t         state;
  hd_root_mode_t     mode;
  logic              metric_select;

  logic [SSD_W-1:0]  sum_sq_diff;
  logic [SUM_W-1:0]  sum_first;
  logic [SUM_W-1:0]  sum_second;
  logic [BC_W-1:0]   sum_root_products;
  logic [CW-1:0]     bins_seen;

  logic [BIN_W-1:0]  bin_mask;
  logic [BIN_W-1:0]  a_q;
  logic [BIN_W-1:0]  b_q;
  logic              last_q;
  logic [PROD_W-1:0] mul_out;
  logic [P_W-1:0]    p_q;
  logic [RAD_W-1:0]  rad;
  logic [DIST_W-1:0] root;
  logic [UNIT_W-1:0] rem;
  logic [BC_W-1:0]   frac;
  logic [CNT_W-1:0]  cnt;

  logic [31:0]       mul_x;
  logic [31:0]       mul_y;
  logic [BIN_W-1:0]  diff;
  logic [UNIT_W-1:0] unit_x;
  logic [UNIT_W-1:0] unit_y;
  logic [UNIT_W:0]   unit_full;
  logic              unit_ge;
  logic [UNIT_W-1:0] unit_sub;
  logic [DIST_W-1:0] root_new;
  logic [33:0]       hd_rad;
  logic [SSD_W:0]    ssd_sum;
  logic [SUM_W:0]    first_sum;
  logic [SUM_W:0]    second_sum;
  logic [BC_W:0]     bc_sum;
  logic              counting;

  always_comb begin
    for (int i = 0; i < BIN_W; i++) begin
      bin_mask[i] = (i < BIN_BITS);
    end
  end

  assign busy     = (state != S_IDLE);
  assign counting = (bins_seen < BIN_LIMIT);
  assign diff     = (a_q > b_q) ? (a_q - b_q) : (b_q - a_q);

  // Shared multiplier operands
  always_comb begin
    unique case (state)
      S_MULAB: begin
        mul_x = {16'd0, a_q};
        mul_y = {16'd0, b_q};
      end
      S_MULDD: begin
        mul_x = {16'd0, diff};
        mul_y = {16'd0, diff};
      end
      S_MULP: begin
        mul_x = {8'd0, sum_first};
        mul_y = {8'd0, sum_second};
      end
      default: begin
        mul_x = sum_root_products;
        mul_y = sum_root_products;
      end
    endcase
  end

  // Shared compare/subtract unit: root trial, divide step, ratio check
  always_comb begin
    unique case (state)
      S_ROOT: begin
        unit_x = {rem[UNIT_W-3:0], rad[RAD_W-1 -: 2]};
        unit_y = {11'd0, root, 2'b01};
      end
      S_DIV: begin
        unit_x = {rem[UNIT_W-2:0], 1'b0};
        unit_y = {1'b0, p_q};
      end
      default: begin
        unit_x = mul_out[UNIT_W-1:0];
        unit_y = {1'b0, p_q};
      end
    endcase
  end

  assign unit_full = {1'b0, unit_x} - {1'b0, unit_y};
  assign unit_ge   = !unit_full[UNIT_W];
  assign unit_sub  = unit_full[UNIT_W-1:0];
  assign root_new  = {root[DIST_W-2:0], unit_ge};

  // Hellinger radicand 2^32 - S, clamped at zero
  assign hd_rad = (root_new[DIST_W-1:32] != '0) ? 34'd0
                : (34'h1_0000_0000 - {2'b00, root_new[31:0]});

  assign ssd_sum    = {1'b0, sum_sq_diff} + {9'd0, mul_out[31:0]};
  assign first_sum  = {1'b0, sum_first} + {9'd0, a_q};
  assign second_sum = {1'b0, sum_second} + {9'd0, b_q};
  assign bc_sum     = {1'b0, sum_root_products} + {17'd0, root[15:0]};

  // Control and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      done              <= 1'b0;
      metric_select     <= METRIC_L2;
      sum_sq_diff       <= '0;
      sum_first         <= '0;
      sum_second        <= '0;
      sum_root_products <= '0;
      bins_seen         <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        metric_select <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            priority if (counting) begin
              state <= S_MULAB;
            end else if (req.last_bin) begin
              state <= S_FINAL;
            end
          end
        end
        S_MULAB:  state <= S_MULDD;
        S_MULDD:  state <= S_ACC;
        S_ACC: begin
          sum_sq_diff <= ssd_sum[SSD_W] ? '1 : ssd_sum[SSD_W-1:0];
          sum_first   <= first_sum[SUM_W] ? '1 : first_sum[SUM_W-1:0];
          sum_second  <= second_sum[SUM_W] ? '1 : second_sum[SUM_W-1:0];
          state       <= S_ROOT;
        end
        S_ROOT: begin
          if (cnt == 6'd1) begin
            unique case (mode)
              RT_BIN:  state <= S_BCACC;
              RT_HS:   state <= S_ROOT;
              default: state <= S_IDLE;
            endcase
            if (mode == RT_EUC || mode == RT_HD) begin
              done              <= 1'b1;
              sum_sq_diff       <= '0;
              sum_first         <= '0;
              sum_second        <= '0;
              sum_root_products <= '0;
              bins_seen         <= '0;
            end
          end
        end
        S_BCACC: begin
          sum_root_products <= bc_sum[BC_W] ? '1 : bc_sum[BC_W-1:0];
          bins_seen         <= bins_seen + 1'b1;
          state             <= last_q ? S_FINAL : S_IDLE;
        end
        S_FINAL: begin
          priority if (metric_select == METRIC_L2) begin
            state <= S_ROOT;
          end else if (sum_first == '0 || sum_second == '0) begin
            state <= S_IDLE;
          end else begin
            state <= S_MULP;
          end
          if (metric_select == METRIC_HELL &&
              (sum_first == '0 || sum_second == '0)) begin
            done              <= 1'b1;
            sum_sq_diff       <= '0;
            sum_first         <= '0;
            sum_second        <= '0;
            sum_root_products <= '0;
            bins_seen         <= '0;
          end
        end
        S_MULP:   state <= S_MULBC;
        S_MULBC:  state <= S_DIVCHK;
        S_DIVCHK: begin
          // ratio of one or more: radicand is not positive, distance 0
          if (mul_out[PROD_W-1:UNIT_W] != '0 || unit_ge) begin
            state             <= S_IDLE;
            done              <= 1'b1;
            sum_sq_diff       <= '0;
            sum_first         <= '0;
            sum_second        <= '0;
            sum_root_products <= '0;
            bins_seen         <= '0;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == 6'd1) begin
            state <= S_SQS;
          end
        end
        S_SQS:    state <= S_ROOT;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      a_q    <= req.bin_a & bin_mask;
      b_q    <= req.bin_b & bin_mask;
      last_q <= req.last_bin;
    end
    if (state == S_MULAB || state == S_MULDD || state == S_MULP || state == S_MULBC) begin
      mul_out <= mul_x * mul_y;
    end
    if (state == S_MULBC) begin
      p_q <= mul_out[P_W-1:0];
    end

    unique case (state)
      S_MULDD: begin
        rad  <= {mul_out[31:0], 40'd0};
        root <= '0;
        rem  <= '0;
        cnt  <= STEPS_BIN;
        mode <= RT_BIN;
      end
      S_FINAL: begin
        rad  <= {sum_sq_diff, 32'd0};
        root <= '0;
        rem  <= '0;
        cnt  <= STEPS_EUC;
        mode <= RT_EUC;
        rsp.distance <= '0;
        rsp.status   <= (metric_select == METRIC_HELL) ? STATUS_EMPTY : STATUS_OK;
      end
      S_DIVCHK: begin
        rem  <= mul_out[UNIT_W-1:0];
        frac <= '0;
        cnt  <= STEPS_DIV;
        rsp.distance <= '0;
        rsp.status   <= STATUS_OK;
      end
      S_DIV: begin
        rem  <= unit_ge ? unit_sub : {rem[UNIT_W-2:0], 1'b0};
        frac <= {frac[BC_W-2:0], unit_ge};
        cnt  <= cnt - 1'b1;
      end
      S_SQS: begin
        rad  <= {frac, 40'd0};
        root <= '0;
        rem  <= '0;
        cnt  <= STEPS_HS;
        mode <= RT_HS;
      end
      S_ROOT: begin
        if (cnt == 6'd1 && mode == RT_HS) begin
          // hand the radicand 2^32 - S over to the final root
          rad  <= {hd_rad, 38'd0};
          root <= '0;
          rem  <= '0;
          cnt  <= STEPS_HD;
          mode <= RT_HD;
        end else begin
          rad  <= {rad[RAD_W-3:0], 2'b00};
          root <= root_new;
          rem  <= unit_ge ? unit_sub : {rem[UNIT_W-3:0], rad[RAD_W-1 -: 2]};
          cnt  <= cnt - 1'b1;
        end
        if (cnt == 6'd1 && (mode == RT_EUC || mode == RT_HD)) begin
          rsp.distance <= root_new;
          rsp.status   <= STATUS_OK;
        end
      end
      default: begin
        rad <= rad;
      end
    endcase
  end

  // Checks
  a_onehot_state: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register is not one-hot");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STATUS_EMPTY) |-> (rsp.distance == '0))
    else $error("empty histogram result carries a distance");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.last_bin) |=> busy)
    else $error("last bin pair did not start the final sequence");

  a_bins_bound: assert property (@(posedge clk) disable iff (rst)
    bins_seen <= BIN_LIMIT)
    else $error("bin counter passed MAX_BINS");

endmodule
